FILE: hw/rtl/akvt_pkg.sv
`default_nettype none

package akvt_pkg;

  localparam int DATA_W = 64;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_GET_KEY = 2'd1,
    OP_SET     = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic [DATA_W-1:0]      data;
    logic                   status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_init;
    logic shift;
    logic append;
    logic set_hit;
    logic dec;
    logic respond;
    logic found;
    logic status;
    logic give_data;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic hit;
    logic scan_end;
    logic full;
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/akvt_ctrl.sv
`default_nettype none

module akvt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire akvt_pkg::sts_t  sts,
  output akvt_pkg::cmd_t       cmd,
  output logic                 busy
);

  akvt_pkg::state_t state;
  akvt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= akvt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      akvt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = akvt_pkg::ST_SCAN;
        end
      end
      akvt_pkg::ST_SCAN: begin
        if (sts.hit) begin
          if (sts.op == akvt_pkg::OP_DELETE) begin
            state_next = akvt_pkg::ST_SHIFT;
          end else begin
            state_next = akvt_pkg::ST_IDLE;
          end
        end else if (sts.scan_end) begin
          state_next = akvt_pkg::ST_IDLE;
        end
      end
      akvt_pkg::ST_SHIFT: begin
        if (sts.scan_end) begin
          state_next = akvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = akvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      akvt_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      akvt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          case (sts.op)
            akvt_pkg::OP_GET, akvt_pkg::OP_GET_KEY: begin
              cmd.respond   = 1'b1;
              cmd.found     = 1'b1;
              cmd.give_data = 1'b1;
            end
            akvt_pkg::OP_SET: begin
              cmd.set_hit = 1'b1;
              cmd.respond = 1'b1;
              cmd.found   = 1'b1;
            end
            default: begin
              cmd.shift_init = 1'b1;
            end
          endcase
        end else if (sts.scan_end) begin
          cmd.respond = 1'b1;
          if (sts.op == akvt_pkg::OP_SET) begin
            // A new key goes at the end unless the table is already full.
            cmd.append = !sts.full;
            cmd.status = sts.full;
          end
        end
      end
      akvt_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.scan_end) begin
          cmd.dec     = 1'b1;
          cmd.respond = 1'b1;
          cmd.found   = 1'b1;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/akvt_dpath.sv
`default_nettype none

module akvt_dpath #(
  parameter int CAPACITY = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire akvt_pkg::req_t  req_in,
  input  wire akvt_pkg::cmd_t  cmd,
  output akvt_pkg::sts_t       sts,
  output akvt_pkg::rsp_t       result,
  output logic                 done
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  akvt_pkg::req_t req;

  logic [akvt_pkg::DATA_W-1:0] key_mem [CAPACITY];
  logic [akvt_pkg::DATA_W-1:0] val_mem [CAPACITY];

  logic [CW-1:0] ptr;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          rd_vld;
  logic [akvt_pkg::DATA_W-1:0] rd_key;
  logic [akvt_pkg::DATA_W-1:0] rd_val;

  logic          issue;
  logic          match;
  logic          key_we;
  logic          val_we;
  logic [IW-1:0] wr_addr;
  logic [akvt_pkg::DATA_W-1:0] wr_key;
  logic [akvt_pkg::DATA_W-1:0] wr_val;
  logic [CW-1:0] rd_idx_dn;

  assign issue     = (cmd.scan || cmd.shift) && (ptr < count);
  assign rd_idx_dn = rd_idx - 1'b1;

  always_comb begin
    if (akvt_pkg::op_t'(req.operation) == akvt_pkg::OP_GET_KEY) begin
      match = (rd_val == req.value);
    end else begin
      match = (rd_key == req.key);
    end
  end

  always_comb begin
    sts.op       = akvt_pkg::op_t'(req.operation);
    sts.hit      = rd_vld && match;
    sts.scan_end = !rd_vld && (ptr >= count);
    sts.full     = (count == CAP);
  end

  always_comb begin
    if (cmd.append) begin
      count_next = count + 1'b1;
    end else if (cmd.dec) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  // During a delete each entry read at ptr is written one place lower in the cycle after the read.
  always_comb begin
    key_we  = 1'b0;
    val_we  = 1'b0;
    wr_addr = count[IW-1:0];
    wr_key  = req.key;
    wr_val  = req.value;
    if (cmd.append) begin
      key_we = 1'b1;
      val_we = 1'b1;
    end else if (cmd.set_hit) begin
      val_we  = 1'b1;
      wr_addr = rd_idx[IW-1:0];
    end else if (cmd.shift && rd_vld) begin
      key_we  = 1'b1;
      val_we  = 1'b1;
      wr_addr = rd_idx_dn[IW-1:0];
      wr_key  = rd_key;
      wr_val  = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_val <= val_mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      rd_vld <= 1'b0;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.respond;
      if (cmd.load) begin
        ptr    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.shift_init) begin
        ptr    <= rd_idx + 1'b1;
        rd_vld <= 1'b0;
      end else begin
        rd_vld <= issue;
        if (issue) begin
          ptr <= ptr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_in;
    end
    if (issue) begin
      rd_idx <= ptr;
    end
    if (cmd.respond) begin
      result.found       <= cmd.found;
      result.status      <= cmd.status;
      result.entry_count <= akvt_pkg::COUNT_OUT_W'(count_next);
      if (!cmd.give_data) begin
        result.data <= '0;
      end else if (akvt_pkg::op_t'(req.operation) == akvt_pkg::OP_GET_KEY) begin
        result.data <= rd_key;
      end else begin
        result.data <= rd_val;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/assoc_key_value_table.sv
`default_nettype none

// Ordered key/value table of up to CAPACITY pairs, searched linearly from the
// oldest entry. A request is taken when start is high and busy is low; its
// result appears on result for exactly one cycle with done high, and the
// receiver cannot stall it, so it must be captured in that cycle. The scan
// reads one entry per cycle through the single read port of the key and value
// memories, whose read data is registered; a request stops at its first match
// or, on a miss, after the last entry held. A delete then moves every later
// entry down one place, one per cycle through the same port. A new request
// may be started in the cycle that done is high.
module assoc_key_value_table #(
  parameter int CAPACITY = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire akvt_pkg::req_t  req,
  output logic                 busy,
  output logic                 done,
  output akvt_pkg::rsp_t       result
);

  akvt_pkg::cmd_t cmd;
  akvt_pkg::sts_t sts;

  akvt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  akvt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req_in (req),
    .cmd    (cmd),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

  // Every result closes a request that was in flight.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  a_no_double_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> !result.found)
    else $error("full status on a set that found its key");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> ((CAPACITY > 31) || (int'(result.entry_count) <= CAPACITY)))
    else $error("entry count beyond capacity");

endmodule

`default_nettype wire
